### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/atbs_pkg.sv
// ---------------------------------------------------------------------------
// atbs_pkg
// Types, widths and codes of the append-only table with binary search.
// ---------------------------------------------------------------------------
`default_nettype none

package atbs_pkg;

   // Default table depth
   localparam int unsigned ATBS_ENTRIES = 128;

   // Beat field widths
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned INDEX_W  = 7;
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned PROBES_W = 4;

   // Request tdata: value, index, zero fill to whole bytes
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned REQ_VALUE_LSB = 0;
   localparam int unsigned REQ_INDEX_LSB = 32;

   // Response tdata: found, probes, read_data, error, zero fill
   localparam int unsigned RSP_TDATA_W = 40;
   localparam int unsigned RSP_FOUND_LSB = 0;
   localparam int unsigned RSP_PROBES_LSB = 1;
   localparam int unsigned RSP_RDATA_LSB = 5;
   localparam int unsigned RSP_ERROR_LSB = 37;

   // Operation codes carried in req_tuser
   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### sv/atbs_ram.sv
// ---------------------------------------------------------------------------
// atbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module atbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/append_table_binary_search.sv
// ---------------------------------------------------------------------------
// append_table_binary_search
// Append-only table of signed 32-bit values with read by index and binary
// search over the entries written so far.
// ---------------------------------------------------------------------------
// Use:
//   req_* beats carry one operation (tuser: append, search, read) with a
//   value and an index; each yields exactly one rsp_* beat with found,
//   probes, read_data and error.
//   Order: an append, a rejected read or an unused code goes from idle
//   straight to the finish state, a read passes the read-wait state and a
//   search stays in the search state while it probes (no probe on an empty
//   table). Finish loads the output register that drives rsp_tvalid once
//   that register is free; only then is the next req beat taken in idle.
//   In each search probe the table RAM's registered read feeds a
//   compare that picks the next midpoint and issues the next read, so a
//   search costs at most floor(log2(ENTRIES)) + 1 probes.
//   One operation is in work at a time; req_tready is high while the
//   sequencer is idle, also while an earlier result waits in the output
//   register.
//   Reset clears the count and the handshakes; table contents stay
//   undefined and are never visible, as only entries below count are read.
//   A stalled rsp_tready holds the output beat; a finished result then
//   waits in the sequencer until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module append_table_binary_search
   import atbs_pkg::*;
#(
   parameter int unsigned ENTRIES = ATBS_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], index[38:32], zero [39]
   input  wire logic [FUNC_W-1:0]      req_tuser,  // func[1:0]
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata   // found[0], probes[4:1], read_data[36:5],
                                                   // error[37], zero [39:38]
);

   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   // Request fields
   logic [VALUE_W-1:0] req_value;
   logic [INDEX_W-1:0] req_index;
   func_type           req_func;

   assign req_value = req_tdata[REQ_VALUE_LSB +: VALUE_W];
   assign req_index = req_tdata[REQ_INDEX_LSB +: INDEX_W];
   assign req_func  = func_type'(req_tuser);

   // Control registers
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Work registers
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hp1_ff, hp1_in;   // one past the upper bound
   logic [CW-1:0]        mid_ff, mid_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [PROBES_W-1:0]  probes_ff, probes_in;
   logic                 found_ff, found_in;
   logic                 error_ff, error_in;
   logic [VALUE_W-1:0]   rdata_ff, rdata_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic                 ram_we;
   logic [AW-1:0]        ram_wr_addr;
   logic                 ram_re;
   logic [AW-1:0]        ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   // Derived conditions
   logic                 table_full;
   logic                 index_ok;
   logic                 rsp_load;
   logic [CW-1:0]        first_mid;
   logic                 val_eq;
   logic                 val_gt;
   logic [CW-1:0]        lo_next;
   logic [CW-1:0]        hp1_next;
   logic [CW:0]          mid_sum;
   logic [CW-1:0]        mid_next;

   atbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign table_full = (count_ff == CW'(ENTRIES));
   assign index_ok   = ({{CW{1'b0}}, req_index} < {{INDEX_W{1'b0}}, count_ff});
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign first_mid  = (count_ff - CW'(1)) >> 1;

   // Narrow the range past the probed middle
   assign val_eq   = (val_ff == ram_rd_data);
   assign val_gt   = ($signed(val_ff) > $signed(ram_rd_data));
   assign lo_next  = val_gt ? (mid_ff + CW'(1)) : lo_ff;
   assign hp1_next = val_gt ? hp1_ff : mid_ff;
   assign mid_sum  = {1'b0, lo_next} + {1'b0, hp1_next} - (CW + 1)'(1);
   assign mid_next = mid_sum[CW:1];

   // Sequencer: next state and RAM control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      hp1_in      = hp1_ff;
      mid_in      = mid_ff;
      val_in      = val_ff;
      probes_in   = probes_ff;
      found_in    = found_ff;
      error_in    = error_ff;
      rdata_in    = rdata_ff;
      ram_we      = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_re      = 1'b0;
      ram_rd_addr = '0;
      req_tready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               found_in  = 1'b0;
               probes_in = '0;
               rdata_in  = '0;
               error_in  = 1'b0;
               val_in    = req_value;
               state_in  = ST_FINISH;
               case (req_func)
                  FUNC_APPEND: begin
                     if (!table_full) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        error_in = 1'b1;
                     end
                  end
                  FUNC_SEARCH: begin
                     lo_in  = '0;
                     hp1_in = count_ff;
                     if (count_ff != '0) begin
                        mid_in      = first_mid;
                        ram_re      = 1'b1;
                        ram_rd_addr = first_mid[AW-1:0];
                        state_in    = ST_SEARCH;
                     end
                  end
                  FUNC_READ: begin
                     if (index_ok) begin
                        ram_re      = 1'b1;
                        ram_rd_addr = AW'(req_index);
                        state_in    = ST_READ_WAIT;
                     end else begin
                        error_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rdata_in = ram_rd_data;
            state_in = ST_FINISH;
         end
         ST_SEARCH: begin
            probes_in = probes_ff + PROBES_W'(1);
            if (val_eq) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               lo_in  = lo_next;
               hp1_in = hp1_next;
               if (lo_next < hp1_next) begin
                  mid_in      = mid_next;
                  ram_re      = 1'b1;
                  ram_rd_addr = mid_next[AW-1:0];
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[RSP_FOUND_LSB]                = found_ff;
         rsp_data_in[RSP_PROBES_LSB +: PROBES_W]   = probes_ff;
         rsp_data_in[RSP_RDATA_LSB +: VALUE_W]     = rdata_ff;
         rsp_data_in[RSP_ERROR_LSB]                = error_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hp1_ff      <= hp1_in;
      mid_ff      <= mid_in;
      val_ff      <= val_in;
      probes_ff   <= probes_in;
      found_ff    <= found_in;
      error_ff    <= error_in;
      rdata_ff    <= rdata_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### sv/atbs_checker.sv
// ---------------------------------------------------------------------------
// atbs_checker
// Port-level checks on the response beats of the table block.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module atbs_checker
   import atbs_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic [FUNC_W-1:0]      req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                rsp_found;
   logic [PROBES_W-1:0] rsp_probes;
   logic [VALUE_W-1:0]  rsp_rdata;
   logic                rsp_error;
   logic                req_beat;

   assign rsp_found  = rsp_tdata[RSP_FOUND_LSB];
   assign rsp_probes = rsp_tdata[RSP_PROBES_LSB +: PROBES_W];
   assign rsp_rdata  = rsp_tdata[RSP_RDATA_LSB +: VALUE_W];
   assign rsp_error  = rsp_tdata[RSP_ERROR_LSB];
   assign req_beat   = req_tvalid && req_tready && (req_tdata != '1) && (req_tuser != '1);

   // A stalled response beat holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response beat changed while stalled")

   // A hit needs at least one probe
   `ASSERT_CLK(a_found_probed, clock, reset, rsp_tvalid && rsp_found |-> rsp_probes != '0, "search hit without a probe")

   // Nonzero read data does not mix with search or error flags
   `ASSERT_CLK(a_kind_clean, clock, reset, rsp_tvalid && (rsp_rdata != '0) |-> !rsp_found && !rsp_error && (rsp_probes == '0), "read data mixed with search or error flags")

   // An error never comes with a hit
   `ASSERT_CLK(a_err_no_hit, clock, reset, rsp_tvalid |-> !(rsp_found && rsp_error), "error and hit in one beat")

   // No response beat straight after a reset cycle that took a request beat whose tdata and tuser are not all ones
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid || !$past(req_beat), "response beat right after reset")

endmodule

bind append_table_binary_search atbs_checker u_atbs_checker (.*);

`default_nettype wire
